@@ hw/rtl/qcse_pkg.sv @@
// qcse_pkg: shared types and constants for the quadtree center-sample encoder.
// No dependencies.
`default_nettype none

package qcse_pkg;

    localparam int SIZE_W   = 9;
    localparam int COORD_W  = 8;
    localparam int COLOR_W  = 8;
    localparam int PIXEL_W  = 3 * COLOR_W;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 14;
    localparam int COUNT_W  = 15;
    localparam int NEXT_W   = 3;

    localparam int LEAF_SPAN = 2;   // r1 - r0 <= 2 means 3 or fewer rows

    localparam logic [1:0] CMD_STORE   = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_FETCH   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REP     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RESTART = 3'd4;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [NEXT_W-1:0] QUAD_FIRST_NEXT = 3'd1;
    localparam logic [NEXT_W-1:0] QUAD_END        = 3'd4;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_REJECT  = 2'd1,
        OP_RESTART = 2'd2,
        OP_FETCH   = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIXEL_W-1:0] pixel;
        logic [SIZE_W-1:0]  h_last;
        logic [SIZE_W-1:0]  w_last;
    } queue_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/quadtree_center_sample_encoder_unit.sv @@
// Quadtree center-sample encoder: front classifier, 2-entry queue, walk back end.
// Store, reject, restart: queue then result register, 1 per cycle while no fetch walks.
// Fetch: after the queue, pops exhausted frames (S_POP; skipped on the first fetch after a
// restart), descends levels (S_DESCEND), reads the center (S_READ), result registered.
// Reset: size registers 256, walk finished, stack empty, queue empty; pixel RAM not cleared.
// Results are strobed for one cycle on result_valid and cannot be stalled.
`default_nettype none

module quadtree_center_sample_encoder_unit #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STACK_DEPTH = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    command,
    input  wire logic [qcse_pkg::COORD_W-1:0]  pixel_row,
    input  wire logic [qcse_pkg::COORD_W-1:0]  pixel_col,
    input  wire logic [qcse_pkg::COLOR_W-1:0]  red_in,
    input  wire logic [qcse_pkg::COLOR_W-1:0]  green_in,
    input  wire logic [qcse_pkg::COLOR_W-1:0]  blue_in,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [qcse_pkg::SIZE_W-1:0]   cfg_data,
    output logic                               result_valid,
    output logic [qcse_pkg::STATUS_W-1:0]      status,
    output logic [qcse_pkg::COLOR_W-1:0]       red_out,
    output logic [qcse_pkg::COLOR_W-1:0]       green_out,
    output logic [qcse_pkg::COLOR_W-1:0]       blue_out,
    output logic [qcse_pkg::INDEX_W-1:0]       rep_index,
    output logic                               last_rep
);

    import qcse_pkg::*;

    queue_entry_t push_entry;
    queue_entry_t head;
    logic         push;
    logic         pop;
    logic         queue_full;
    logic         head_valid;

    qcse_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .pixel_row  (pixel_row),
        .pixel_col  (pixel_col),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .entry      (push_entry)
    );

    qcse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    qcse_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .status       (status),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .rep_index    (rep_index),
        .last_rep     (last_rep)
    );

endmodule

`default_nettype wire

@@ hw/rtl/qcse_ram.sv @@
// qcse_ram: generic single-port RAM, one read or write per cycle, registered read.
// No dependencies.
`default_nettype none

module qcse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/qcse_front.sv @@
// qcse_front: size registers, command accept and classification into queue entries.
// Depends on qcse_pkg.
`default_nettype none

module qcse_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [1:0]                    command,
    input  wire logic [qcse_pkg::COORD_W-1:0]  pixel_row,
    input  wire logic [qcse_pkg::COORD_W-1:0]  pixel_col,
    input  wire logic [qcse_pkg::COLOR_W-1:0]  red_in,
    input  wire logic [qcse_pkg::COLOR_W-1:0]  green_in,
    input  wire logic [qcse_pkg::COLOR_W-1:0]  blue_in,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_index,
    input  wire logic [qcse_pkg::SIZE_W-1:0]   cfg_data,
    output logic                               cfg_ready,
    input  wire logic                          queue_full,
    output logic                               busy,
    output logic                               push,
    output qcse_pkg::queue_entry_t             entry
);

    import qcse_pkg::*;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              out_of_size;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned lim);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (int'(v) > lim)
        begin
            r = SIZE_W'(lim);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start && !queue_full;

    assign w_eff = eff_size(width_reg, MAX_WIDTH);
    assign h_eff = eff_size(height_reg, MAX_HEIGHT);
    assign out_of_size = ({1'b0, pixel_row} >= h_eff) || ({1'b0, pixel_col} >= w_eff);

    always_comb
    begin
        entry.row    = pixel_row;
        entry.col    = pixel_col;
        entry.pixel  = {red_in, green_in, blue_in};
        entry.h_last = h_eff - SIZE_W'(1);
        entry.w_last = w_eff - SIZE_W'(1);
        case (command)
            CMD_STORE:   entry.kind = out_of_size ? OP_REJECT : OP_STORE;
            CMD_RESTART: entry.kind = OP_RESTART;
            CMD_FETCH:   entry.kind = OP_FETCH;
            default:     entry.kind = OP_REJECT;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/qcse_queue.sv @@
// qcse_queue: two-entry FIFO of classified transactions between front and back.
// Depends on qcse_pkg.
`default_nettype none

module qcse_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire qcse_pkg::queue_entry_t push_entry,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        head_valid,
    output qcse_pkg::queue_entry_t      head
);

    import qcse_pkg::*;

    queue_entry_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/qcse_back.sv @@
// qcse_back: executes queued transactions, pixel RAM and quadtree walk sequencer.
// Depends on qcse_pkg and qcse_ram.
`default_nettype none

module qcse_back #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STACK_DEPTH = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire qcse_pkg::queue_entry_t        head,
    output logic                               pop,
    output logic                               result_valid,
    output logic [qcse_pkg::STATUS_W-1:0]      status,
    output logic [qcse_pkg::COLOR_W-1:0]       red_out,
    output logic [qcse_pkg::COLOR_W-1:0]       green_out,
    output logic [qcse_pkg::COLOR_W-1:0]       blue_out,
    output logic [qcse_pkg::INDEX_W-1:0]       rep_index,
    output logic                               last_rep
);

    import qcse_pkg::*;

    localparam int HCAP = (MAX_HEIGHT > 512) ? 512 : MAX_HEIGHT;
    localparam int WCAP = (MAX_WIDTH > 512) ? 512 : MAX_WIDTH;
    localparam int RW   = $clog2(HCAP);
    localparam int CW   = $clog2(WCAP);
    localparam int DEPTH_ALL = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(DEPTH_ALL);
    localparam int DW   = $clog2(STACK_DEPTH + 1);
    localparam int SIW  = $clog2(STACK_DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_POP     = 4'b0010,
        S_DESCEND = 4'b0100,
        S_READ    = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;
    logic               walk_done_reg, walk_done_next;
    logic               start_pending_reg, start_pending_next;
    logic [RW-1:0]      r0_reg, r0_next, r1_reg, r1_next;
    logic [CW-1:0]      c0_reg, c0_next, c1_reg, c1_next;

    logic [RW-1:0]      fr_r0_reg [STACK_DEPTH];
    logic [RW-1:0]      fr_r1_reg [STACK_DEPTH];
    logic [CW-1:0]      fr_c0_reg [STACK_DEPTH];
    logic [CW-1:0]      fr_c1_reg [STACK_DEPTH];
    logic [NEXT_W-1:0]  fr_next_reg [STACK_DEPTH];

    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COLOR_W-1:0]  red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic                last_reg, last_next;

    logic                push_en;
    logic                inc_en;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [PIXEL_W-1:0]  ram_rdata;

    logic [DW-1:0]       depth_m1;
    logic [SIW-1:0]      top_idx;
    logic [SIW-1:0]      push_idx;
    logic [RW-1:0]       t_r0, t_r1, t_mr;
    logic [CW-1:0]       t_c0, t_c1, t_mc;
    logic [NEXT_W-1:0]   t_next;
    logic [RW:0]         t_rsum, cur_rsum;
    logic [CW:0]         t_csum, cur_csum;
    logic [RW-1:0]       cur_mr;
    logic [CW-1:0]       cur_mc;
    logic                is_leaf;
    logic                more;
    logic [AW-1:0]       store_addr;
    logic [AW-1:0]       center_addr;

    assign depth_m1 = depth_reg - DW'(1);
    assign top_idx  = depth_m1[SIW-1:0];
    assign push_idx = depth_reg[SIW-1:0];

    assign t_r0   = fr_r0_reg[top_idx];
    assign t_r1   = fr_r1_reg[top_idx];
    assign t_c0   = fr_c0_reg[top_idx];
    assign t_c1   = fr_c1_reg[top_idx];
    assign t_next = fr_next_reg[top_idx];
    assign t_rsum = {1'b0, t_r0} + {1'b0, t_r1};
    assign t_csum = {1'b0, t_c0} + {1'b0, t_c1};
    assign t_mr   = t_rsum[RW:1];
    assign t_mc   = t_csum[CW:1];

    assign cur_rsum = {1'b0, r0_reg} + {1'b0, r1_reg};
    assign cur_csum = {1'b0, c0_reg} + {1'b0, c1_reg};
    assign cur_mr   = cur_rsum[RW:1];
    assign cur_mc   = cur_csum[CW:1];
    assign is_leaf  = ((r1_reg - r0_reg) <= RW'(LEAF_SPAN))
                   || ((c1_reg - c0_reg) <= CW'(LEAF_SPAN));

    assign store_addr  = AW'(head.row) * ROW_STRIDE + AW'(head.col);
    assign center_addr = AW'(cur_mr) * ROW_STRIDE + AW'(cur_mc);

    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if ((DW'(i) < depth_reg) && (fr_next_reg[i] < QUAD_END))
            begin
                more = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        depth_next         = depth_reg;
        emitted_next       = emitted_reg;
        walk_done_next     = walk_done_reg;
        start_pending_next = start_pending_reg;
        r0_next            = r0_reg;
        r1_next            = r1_reg;
        c0_next            = c0_reg;
        c1_next            = c1_reg;
        res_valid_next     = 1'b0;
        status_next        = status_reg;
        red_next           = '0;
        green_next         = '0;
        blue_next          = '0;
        index_next         = '0;
        last_next          = 1'b0;
        pop                = 1'b0;
        push_en            = 1'b0;
        inc_en             = 1'b0;
        ram_we             = 1'b0;
        ram_addr           = store_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        OP_STORE:
                        begin
                            ram_we         = 1'b1;
                            res_valid_next = 1'b1;
                            status_next    = ST_STORED;
                        end
                        OP_RESTART:
                        begin
                            depth_next         = '0;
                            emitted_next       = '0;
                            walk_done_next     = 1'b0;
                            start_pending_next = 1'b1;
                            res_valid_next     = 1'b1;
                            status_next        = ST_RESTART;
                        end
                        OP_FETCH:
                        begin
                            if (walk_done_reg)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = ST_DONE;
                            end
                            else if (start_pending_reg)
                            begin
                                start_pending_next = 1'b0;
                                r0_next            = '0;
                                r1_next            = RW'(head.h_last);
                                c0_next            = '0;
                                c1_next            = CW'(head.w_last);
                                state_next         = S_DESCEND;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            status_next    = ST_REJECT;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (depth_reg == '0)
                begin
                    walk_done_next = 1'b1;
                    res_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    state_next     = S_IDLE;
                end
                else if (t_next >= QUAD_END)
                begin
                    depth_next = depth_m1;
                end
                else
                begin
                    inc_en = 1'b1;
                    if (!t_next[1])
                    begin
                        r0_next = t_r0;
                        r1_next = t_mr;
                    end
                    else
                    begin
                        r0_next = t_mr + RW'(1);
                        r1_next = t_r1;
                    end
                    if (!t_next[0])
                    begin
                        c0_next = t_c0;
                        c1_next = t_mc;
                    end
                    else
                    begin
                        c0_next = t_mc + CW'(1);
                        c1_next = t_c1;
                    end
                    state_next = S_DESCEND;
                end
            end
            S_DESCEND:
            begin
                if (!is_leaf && (depth_reg < DW'(STACK_DEPTH)))
                begin
                    push_en    = 1'b1;
                    depth_next = depth_reg + DW'(1);
                    r1_next    = cur_mr;
                    c1_next    = cur_mc;
                end
                else
                begin
                    ram_addr   = center_addr;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                res_valid_next = 1'b1;
                status_next    = ST_REP;
                red_next       = ram_rdata[3*COLOR_W-1:2*COLOR_W];
                green_next     = ram_rdata[2*COLOR_W-1:COLOR_W];
                blue_next      = ram_rdata[COLOR_W-1:0];
                index_next     = emitted_reg[INDEX_W-1:0];
                last_next      = !more;
                emitted_next   = emitted_reg + COUNT_W'(1);
                if (!more)
                begin
                    walk_done_next = 1'b1;
                    depth_next     = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            depth_reg         <= '0;
            emitted_reg       <= '0;
            walk_done_reg     <= 1'b1;
            start_pending_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            depth_reg         <= depth_next;
            emitted_reg       <= emitted_next;
            walk_done_reg     <= walk_done_next;
            start_pending_reg <= start_pending_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        status_reg <= status_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
        if (push_en)
        begin
            fr_r0_reg[push_idx]   <= r0_reg;
            fr_r1_reg[push_idx]   <= r1_reg;
            fr_c0_reg[push_idx]   <= c0_reg;
            fr_c1_reg[push_idx]   <= c1_reg;
            fr_next_reg[push_idx] <= QUAD_FIRST_NEXT;
        end
        if (inc_en)
        begin
            fr_next_reg[top_idx] <= t_next + NEXT_W'(1);
        end
    end

    qcse_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH_ALL)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.pixel),
        .rdata (ram_rdata)
    );

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
    assign rep_index    = index_reg;
    assign last_rep     = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/qcse_checker.sv @@
// qcse_checker: port-level assertions for the encoder, bound to the top level.
// Depends on qcse_pkg and quadtree_center_sample_encoder_unit.
`default_nettype none

module qcse_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          result_valid,
    input wire logic [qcse_pkg::STATUS_W-1:0] status,
    input wire logic [qcse_pkg::COLOR_W-1:0]  red_out,
    input wire logic [qcse_pkg::COLOR_W-1:0]  green_out,
    input wire logic [qcse_pkg::COLOR_W-1:0]  blue_out,
    input wire logic [qcse_pkg::INDEX_W-1:0]  rep_index,
    input wire logic                          last_rep
);

    import qcse_pkg::*;

    // non-representative results carry an all-zero payload
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_REP)) |->
        ((red_out == '0) && (green_out == '0) && (blue_out == '0)
         && (rep_index == '0) && !last_rep))
        else $error("payload not zero on non-representative result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        ((status == ST_STORED) || (status == ST_REP) || (status == ST_DONE)
         || (status == ST_REJECT) || (status == ST_RESTART)))
        else $error("undefined status code");

    // queue only fills on an accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted transaction");

endmodule

bind quadtree_center_sample_encoder_unit qcse_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .rep_index    (rep_index),
    .last_rep     (last_rep)
);

`default_nettype wire

@@ tb/sv/tb_quadtree_center_sample_encoder_unit.sv @@
// Self-checking testbench for quadtree_center_sample_encoder_unit: pixel stores, walk restarts,
// leaf fetches, rejected commands and size changes, each response checked against an in-bench model.
// Depends on qcse_pkg and the encoder unit RTL.
`timescale 1ns / 1ps

module tb_quadtree_center_sample_encoder_unit;
    import qcse_pkg::*;

    localparam int IMG_MAX      = 256;
    localparam int STACK_LEVELS = 10;
    localparam int TAIL_CYCLES  = 24;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [INDEX_W-1:0]  seq;
        logic                last;
    } reply_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          command;
    logic [COORD_W-1:0]  pixel_row;
    logic [COORD_W-1:0]  pixel_col;
    logic [COLOR_W-1:0]  red_in;
    logic [COLOR_W-1:0]  green_in;
    logic [COLOR_W-1:0]  blue_in;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [SIZE_W-1:0]   cfg_data;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [COLOR_W-1:0]  red_out;
    logic [COLOR_W-1:0]  green_out;
    logic [COLOR_W-1:0]  blue_out;
    logic [INDEX_W-1:0]  rep_index;
    logic                last_rep;

    quadtree_center_sample_encoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .rep_index    (rep_index),
        .last_rep     (last_rep)
    );

    always #5 clk = ~clk;

    // image mirror and walk state
    logic [PIXEL_W-1:0] pix_mirror  [0:IMG_MAX*IMG_MAX-1];
    bit                 pix_written [0:IMG_MAX*IMG_MAX-1];
    logic [SIZE_W-1:0]  cfg_w = SIZE_RESET;
    logic [SIZE_W-1:0]  cfg_h = SIZE_RESET;
    int                 stk_r0   [STACK_LEVELS];
    int                 stk_r1   [STACK_LEVELS];
    int                 stk_c0   [STACK_LEVELS];
    int                 stk_c1   [STACK_LEVELS];
    int                 stk_next [STACK_LEVELS];
    int                 stack_level = 0;
    logic [COUNT_W-1:0] leaf_count = '0;
    bit                 walk_done = 1'b1;
    bit                 start_pending = 1'b0;

    reply_t pending_replies[$];
    int     error_count = 0;
    int     items_sent = 0;
    int     reps_checked = 0;
    int     walks_completed = 0;
    int     rejects_seen = 0;
    int     burst_left = 0;
    bit     idling = 1'b0;

    function automatic int active_size(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > IMG_MAX)
            return IMG_MAX;
        return int'(v);
    endfunction

    function automatic void split_region(input int a0, input int a1, input int b0,
                                         input int b1, input int q, output int r0,
                                         output int r1, output int c0, output int c1);
        int mr;
        int mc;
        mr = (a0 + a1) / 2;
        mc = (b0 + b1) / 2;
        if (q < 2) begin
            r0 = a0;
            r1 = mr;
        end
        else begin
            r0 = mr + 1;
            r1 = a1;
        end
        if ((q % 2) == 0) begin
            c0 = b0;
            c1 = mc;
        end
        else begin
            c0 = mc + 1;
            c1 = b1;
        end
    endfunction

    // Moves the walk to its next leaf; with commit clear it only looks ahead.
    function automatic bit walk_advance(input bit commit, output int crow, output int ccol,
                                        output bit final_leaf, output logic [INDEX_W-1:0] seq);
        int                 sr0 [STACK_LEVELS];
        int                 sr1 [STACK_LEVELS];
        int                 sc0 [STACK_LEVELS];
        int                 sc1 [STACK_LEVELS];
        int                 snext [STACK_LEVELS];
        int                 r0, r1, c0, c1, d, i;
        bit                 found;
        bit                 more;
        bit                 done;
        bit                 pend;
        logic [COUNT_W-1:0] cnt;
        crow = 0;
        ccol = 0;
        final_leaf = 1'b0;
        seq = '0;
        r0 = 0;
        r1 = 0;
        c0 = 0;
        c1 = 0;
        for (i = 0; i < STACK_LEVELS; i++) begin
            sr0[i] = stk_r0[i];
            sr1[i] = stk_r1[i];
            sc0[i] = stk_c0[i];
            sc1[i] = stk_c1[i];
            snext[i] = stk_next[i];
        end
        d = stack_level;
        cnt = leaf_count;
        done = walk_done;
        pend = start_pending;
        if (done)
            return 1'b0;
        if (pend) begin
            pend = 1'b0;
            r1 = active_size(cfg_h) - 1;
            c1 = active_size(cfg_w) - 1;
        end
        else begin
            found = 1'b0;
            while (!found && d > 0) begin
                if (snext[d-1] >= int'(QUAD_END)) begin
                    d--;
                end
                else begin
                    split_region(sr0[d-1], sr1[d-1], sc0[d-1], sc1[d-1], snext[d-1],
                                 r0, r1, c0, c1);
                    snext[d-1]++;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (commit) begin
                    walk_done = 1'b1;
                    stack_level = 0;
                end
                return 1'b0;
            end
        end
        while (r1 - r0 > LEAF_SPAN && c1 - c0 > LEAF_SPAN && d < STACK_LEVELS) begin
            sr0[d] = r0;
            sr1[d] = r1;
            sc0[d] = c0;
            sc1[d] = c1;
            snext[d] = int'(QUAD_FIRST_NEXT);
            d++;
            split_region(sr0[d-1], sr1[d-1], sc0[d-1], sc1[d-1], 0, r0, r1, c0, c1);
        end
        crow = (r0 + r1) / 2;
        ccol = (c0 + c1) / 2;
        more = 1'b0;
        for (i = 0; i < d; i++)
            if (snext[i] < int'(QUAD_END))
                more = 1'b1;
        seq = cnt[INDEX_W-1:0];
        final_leaf = !more;
        cnt = cnt + 1'b1;
        if (!more) begin
            done = 1'b1;
            d = 0;
        end
        if (commit) begin
            for (i = 0; i < STACK_LEVELS; i++) begin
                stk_r0[i] = sr0[i];
                stk_r1[i] = sr1[i];
                stk_c0[i] = sc0[i];
                stk_c1[i] = sc1[i];
                stk_next[i] = snext[i];
            end
            stack_level = d;
            leaf_count = cnt;
            walk_done = done;
            start_pending = pend;
        end
        return 1'b1;
    endfunction

    function automatic void encoder_step(input logic [1:0] cmd, input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] col,
                                         input logic [PIXEL_W-1:0] pixel);
        reply_t             reply;
        int                 crow, ccol;
        bit                 final_leaf;
        logic [INDEX_W-1:0] seq;
        reply = '0;
        case (cmd)
            CMD_STORE: begin
                if (int'(row) >= active_size(cfg_h) || int'(col) >= active_size(cfg_w)) begin
                    reply.status = ST_REJECT;
                end
                else begin
                    pix_mirror[int'(row) * IMG_MAX + int'(col)] = pixel;
                    pix_written[int'(row) * IMG_MAX + int'(col)] = 1'b1;
                    reply.status = ST_STORED;
                end
            end
            CMD_RESTART: begin
                stack_level = 0;
                leaf_count = '0;
                walk_done = 1'b0;
                start_pending = 1'b1;
                reply.status = ST_RESTART;
            end
            CMD_FETCH: begin
                if (walk_advance(1'b1, crow, ccol, final_leaf, seq)) begin
                    reply.status = ST_REP;
                    {reply.red, reply.green, reply.blue} = pix_mirror[crow * IMG_MAX + ccol];
                    reply.seq = seq;
                    reply.last = final_leaf;
                end
                else begin
                    reply.status = ST_DONE;
                end
            end
            default: reply.status = ST_REJECT;
        endcase
        pending_replies.push_back(reply);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        reply_t want;
        if (rst_n && result_valid) begin
            if (pending_replies.size() == 0) begin
                error_count++;
                $error("unexpected response, status %0d", status);
            end
            else begin
                want = pending_replies.pop_front();
                check_field("status", want.status, status);
                check_field("red_out", want.red, red_out);
                check_field("green_out", want.green, green_out);
                check_field("blue_out", want.blue, blue_out);
                check_field("rep_index", want.seq, rep_index);
                check_field("last_rep", want.last, last_rep);
                if (want.status == ST_REP)
                    reps_checked++;
                if (want.status == ST_REP && want.last)
                    walks_completed++;
                if (want.status == ST_REJECT)
                    rejects_seen++;
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col, input logic [PIXEL_W-1:0] pixel);
        @(negedge clk);
        if (idling && burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        command = cmd;
        pixel_row = row;
        pixel_col = col;
        {red_in, green_in, blue_in} = pixel;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        encoder_step(cmd, row, col, pixel);
        items_sent++;
    endtask

    task automatic send_noise(input logic [1:0] cmd);
        send_item(cmd, 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    // stores the next leaf center first if it was never written
    task automatic fetch_next();
        int                 crow, ccol;
        bit                 final_leaf;
        logic [INDEX_W-1:0] seq;
        if (walk_advance(1'b0, crow, ccol, final_leaf, seq) &&
            !pix_written[crow * IMG_MAX + ccol])
            send_item(CMD_STORE, 8'(crow), 8'(ccol), 24'($urandom));
        send_noise(CMD_FETCH);
    endtask

    task automatic quiesce();
        @(negedge clk);
        start = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
            cfg_w = val;
        else
            cfg_h = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        quiesce();
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 9'd1;
            2: return 9'($urandom_range(257, 511));
            3: return SIZE_RESET;
            4: return 9'($urandom_range(100, 255));
            default: return 9'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic test_directed();
        idling = 1'b0;
        send_noise(CMD_FETCH);
        send_item(CMD_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF);
        send_item(CMD_STORE, 8'd0, 8'd0, 24'h000000);
        send_item(CMD_STORE, 8'd255, 8'd255, 24'hFFFFFF);
        send_item(CMD_STORE, 8'd255, 8'd0, 24'hAA55AA);
        send_item(CMD_STORE, 8'd0, 8'd255, 24'h55AA55);
        send_noise(CMD_RESTART);
        repeat (3) fetch_next();
        // zero sizes act as one pixel
        set_size('0, '0);
        send_item(CMD_STORE, 8'd0, 8'd1, 24'h123456);
        send_item(CMD_STORE, 8'd1, 8'd0, 24'h654321);
        send_item(CMD_STORE, 8'd0, 8'd0, 24'h123456);
        send_noise(CMD_RESTART);
        fetch_next();
        send_noise(CMD_FETCH);
        // oversize values clamp to the maximum
        set_size(9'd511, 9'd300);
        send_item(CMD_STORE, 8'd255, 8'd255, 24'h0F0F0F);
        send_noise(CMD_RESTART);
        fetch_next();
        send_noise(CMD_RESTART);
        fetch_next();
        // three columns: whole image is one leaf
        set_size(9'd3, SIZE_RESET);
        send_noise(CMD_RESTART);
        fetch_next();
        send_noise(CMD_FETCH);
    endtask

    task automatic test_resize_mid_walk();
        int r, c, n;
        set_size(9'd10, 9'd9);
        idling = 1'b1;
        for (r = 0; r < 9; r++)
            for (c = 0; c < 10; c++)
                send_item(CMD_STORE, 8'(r), 8'(c), 24'($urandom));
        send_noise(CMD_RESTART);
        for (n = 0; n < 5; n++)
            fetch_next();
        set_size(9'd1, 9'd1);
        send_item(CMD_STORE, 8'd0, 8'd1, 24'($urandom));
        while (!walk_done)
            fetch_next();
        send_noise(CMD_FETCH);
    endtask

    task automatic test_random_walks();
        int target, fetches, pick;
        target = items_sent + 300;
        while (items_sent < target) begin
            set_size(random_size(), random_size());
            idling = ($urandom_range(0, 3) != 0);
            send_noise(CMD_RESTART);
            fetches = 0;
            while (!walk_done && fetches < 48) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    fetch_next();
                    fetches++;
                end
                else if (pick < 92)
                    send_noise(CMD_STORE);
                else if (pick < 96)
                    send_noise(CMD_UNUSED);
                else
                    send_noise(CMD_RESTART);
            end
            fetch_next();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_STORE;
        pixel_row = '0;
        pixel_col = '0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_resize_mid_walk();
        test_random_walks();
        quiesce();

        $display("covered %0d transactions, %0d leaves checked, %0d walks run to the end",
                 items_sent, reps_checked, walks_completed);
        $display("%0d rejected stores or commands, image sizes from 1x1 up to 256x256",
                 rejects_seen);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
